>>> rtl/core/pwmcalc_pkg.sv
package pwmcalc_pkg;

    localparam int          PERIOD_STEPS     = 1024;
    localparam int          MAX_PRESCALE     = 63;
    localparam logic [31:0] CLOCK_RESET      = 32'd13000000;
    localparam logic [29:0] NS_PER_SECOND    = 30'd1000000000;
    localparam logic [10:0] DUTY_SAT         = 11'd1024;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_PRESCALE = 2'd1;
    localparam logic [1:0] ST_ZERO     = 2'd2;

    // Request as it travels from front to back
    typedef struct packed {
        logic        channel;
        logic [30:0] period;
        logic [30:0] duty;
    } pwmc_req_t;

    // Result fields
    typedef struct packed {
        logic        full_duty;
        logic [10:0] duty_value;
        logic [9:0]  period_value;
        logic [5:0]  prescale_value;
        logic [1:0]  status;
        logic        channel_out;
    } pwmc_res_t;

endpackage

>>> rtl/core/pwmcalc_front.sv
// Accept requests into a short queue; pop feeds the back pipeline.
module pwmcalc_front
    import pwmcalc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  pwmc_req_t in_req,
    output logic      q_valid,
    input  logic      q_ready,
    output pwmc_req_t q_req
);

    localparam int DEPTH = 2;

    pwmc_req_t  mem_reg [DEPTH];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'(DEPTH));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Advance pointers and fill count
    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_req;
        end
    end

endmodule

>>> rtl/core/pwmcalc_back.sv
// Pipelined calculation: multiply, reciprocal divide by 1e9, prescale,
// one-bit-per-stage divides for period and duty, then output register.
module pwmcalc_back
    import pwmcalc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] clock_rate,
    input  logic        q_valid,
    output logic        q_ready,
    input  pwmc_req_t   q_req,
    output logic        out_valid,
    input  logic        out_ready,
    output pwmc_res_t   out_res
);

    localparam int SW  = $clog2(PERIOD_STEPS);
    localparam int PW  = $clog2(MAX_PRESCALE + 2);
    localparam int CW  = 63;
    // Quotient bits for the period divide: cycles / (ps+1) fits SW+1 bits
    localparam int QB  = SW + 1;
    // Duty quotient: (pv+1)*duty/period <= PERIOD_STEPS when duty<period
    localparam int DB  = SW + 1;
    // capture, product, two reciprocal stages, cycle count, period divide,
    // duty product, duty divide
    localparam int NS  = 6 + QB + DB;

    // Per stage payload
    typedef struct packed {
        logic        channel;
        logic [30:0] period;
        logic [30:0] duty;
        logic [62:0] num;     // cycles or running remainder
        logic [PW:0] div;     // prescale + 1
        logic [PW-1:0] ps;
        logic        ps_bad;
        logic [QB-1:0] q;     // period quotient
        logic [42:0] dnum;    // duty numerator remainder
        logic [DB-1:0] dq;
    } stg_t;

    stg_t       st_reg [NS];
    logic [NS-1:0] v_reg;
    logic       adv;
    logic       skid_valid_reg;
    pwmc_res_t  skid_reg;

    // Stall the whole line when the output holds a result that is not taken
    assign adv     = !skid_valid_reg || out_ready;
    assign q_ready = adv;

    // Stage 0: 32x31 product split in a 32x16 and a 32x15 half
    logic [47:0] pl_reg, ph_reg;
    // Stage 1: full product
    logic [62:0] prod_reg;
    // Stages 2 and 3: product times ceil(2^90/1e9) from 32x32 pieces.
    // For products below 2^63 the reciprocal error stays under 1/1e9, so
    // the top bits give the exact quotient.
    localparam logic [60:0] RECIP = 61'd1237940039285380275;
    logic [63:0]  pp_hh_reg, pp_hl_reg, pp_lh_reg, pp_ll_reg;
    logic [63:0]  sm_hh_reg, sm_ll_reg;
    logic [64:0]  sm_mid_reg;
    logic [127:0] rsum;
    logic [62:0]  q_est;

    always_comb begin
        rsum  = {sm_hh_reg, sm_ll_reg} + (128'(sm_mid_reg) << 32);
        q_est = 63'(rsum >> 90);
    end

    // Main pipeline
    stg_t s_n [NS];
    logic [62:0] cyc;
    logic [62:0] psq;
    logic [CW+1:0] trial;
    logic [43:0] dtrial;

    always_comb begin
        for (int k = 0; k < NS; k++) s_n[k] = st_reg[k];
        // stage 0 capture
        s_n[0] = '0;
        s_n[0].channel = q_req.channel;
        s_n[0].period  = q_req.period;
        s_n[0].duty    = q_req.duty;
        // stages 1 to 3 carry the request beside the product
        s_n[1] = st_reg[0];
        s_n[2] = st_reg[1];
        s_n[3] = st_reg[2];
        // stage 4 clamp the cycle count, prescale
        s_n[4] = st_reg[3];
        cyc    = q_est;
        if (cyc == 63'd0) cyc = 63'd1;
        psq    = (cyc - 63'd1) >> SW;
        s_n[4].num    = cyc;
        s_n[4].ps_bad = (psq > 63'(MAX_PRESCALE));
        s_n[4].ps     = PW'(psq);
        s_n[4].div    = (PW+1)'(psq) + (PW+1)'(1);
        // period divide stages, one bit each, MSB first
        for (int k = 0; k < QB; k++) begin
            s_n[5+k] = st_reg[4+k];
            trial = (CW+2)'(st_reg[4+k].div) << (QB-1-k);
            if (!st_reg[4+k].ps_bad && (CW+2)'(st_reg[4+k].num) >= trial) begin
                s_n[5+k].num = st_reg[4+k].num - CW'(trial);
                s_n[5+k].q[QB-1-k] = 1'b1;
            end
        end
        // duty numerator (pv+1)*duty = q*duty
        s_n[5+QB] = st_reg[4+QB];
        s_n[5+QB].dnum = 43'(st_reg[4+QB].q) * 43'(st_reg[4+QB].duty);
        // duty divide stages
        for (int k = 0; k < DB; k++) begin
            s_n[6+QB+k] = st_reg[5+QB+k];
            dtrial = 44'(st_reg[5+QB+k].period) << (DB-1-k);
            if (st_reg[5+QB+k].period != 31'd0 &&
                44'(st_reg[5+QB+k].dnum) >= dtrial) begin
                s_n[6+QB+k].dnum = st_reg[5+QB+k].dnum - 43'(dtrial);
                s_n[6+QB+k].dq[DB-1-k] = 1'b1;
            end
        end
    end

    // Final result formatting
    pwmc_res_t res;
    stg_t      f;
    logic [QB-1:0] pvq;
    always_comb begin
        f   = st_reg[NS-1];
        pvq = f.q - QB'(1);
        res = '0;
        res.channel_out = f.channel;
        if (f.ps_bad) begin
            res.status = ST_PRESCALE;
        end else if (f.duty == f.period) begin
            res.full_duty      = 1'b1;
            res.prescale_value = 6'(f.ps);
            res.period_value   = 10'(pvq);
        end else if (f.period == 31'd0) begin
            res.status = ST_ZERO;
        end else begin
            res.prescale_value = 6'(f.ps);
            res.period_value   = 10'(pvq);
            if (f.duty > f.period || 32'(f.dq) > 32'(DUTY_SAT)) begin
                res.duty_value = DUTY_SAT;
            end else begin
                res.duty_value = 11'(f.dq);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pl_reg     <= 48'(clock_rate) * 48'(q_req.period[15:0]);
            ph_reg     <= 48'(clock_rate) * 48'(q_req.period[30:16]);
            prod_reg   <= 63'(pl_reg) + (63'(ph_reg) << 16);
            pp_hh_reg  <= 64'(prod_reg[62:32]) * 64'(RECIP[60:32]);
            pp_hl_reg  <= 64'(prod_reg[62:32]) * 64'(RECIP[31:0]);
            pp_lh_reg  <= 64'(prod_reg[31:0]) * 64'(RECIP[60:32]);
            pp_ll_reg  <= 64'(prod_reg[31:0]) * 64'(RECIP[31:0]);
            sm_hh_reg  <= pp_hh_reg;
            sm_mid_reg <= 65'(pp_hl_reg) + 65'(pp_lh_reg);
            sm_ll_reg  <= pp_ll_reg;
            for (int k = 0; k < NS; k++) st_reg[k] <= s_n[k];
        end
    end

    // Valid line and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg          <= '0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                v_reg          <= {v_reg[NS-2:0], q_valid};
                skid_valid_reg <= v_reg[NS-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) skid_reg <= res;
    end

    assign out_valid = skid_valid_reg;
    assign out_res   = skid_reg;

endmodule

>>> rtl/core/pwm_period_duty_register_calc.sv
// PWM period/duty calculator. One request per clock is accepted while the
// result side does not stall, and results leave in order: each request
// passes the two-entry input queue, 28 pipeline stages (two for the
// clock-rate product, three for the reciprocal divide by 1e9 and prescale,
// eleven one-bit stages for the period divide, one for the duty product,
// eleven for the duty divide) and the output register. A stall at the result
// side holds the whole pipeline, while the input queue keeps accepting
// until it is full. clock_rate_hz may be written only while idle.
module pwm_period_duty_register_calc
    import pwmcalc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // channel, period_time_ns, duty_time_ns
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // channel_out, status, prescale_value,
                                   // period_value, duty_value, full_duty
);

    logic [31:0] clk_rate_reg;
    pwmc_req_t   in_req, q_req;
    logic        q_valid, q_ready;
    pwmc_res_t   res;

    // Hold the clock rate register
    always_ff @(posedge aclk) begin
        if (!aresetn) clk_rate_reg <= CLOCK_RESET;
        else if (cfg_wr_en) clk_rate_reg <= cfg_wr_data;
    end

    assign in_req.channel = s_tdata[0];
    assign in_req.period  = s_tdata[31:1];
    assign in_req.duty    = s_tdata[62:32];

    pwmcalc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_req(in_req),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    pwmcalc_back u_back (
        .aclk(aclk), .aresetn(aresetn), .clock_rate(clk_rate_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = {1'b0, res};

endmodule

>>> rtl/core/pwmcalc_checker.sv
module pwmcalc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed");
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:1] != 2'd3) else $error("bad status");
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:1] != 2'd0 |-> m_tdata[30:3] == 28'd0)
        else $error("error result not cleared");
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[30] |-> m_tdata[29:19] == 11'd0)
        else $error("full duty with count");

endmodule

bind pwm_period_duty_register_calc pwmcalc_checker u_chk (.*);

>>> tb/tb.sv
module tb;
    import pwmcalc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        channel;
        logic [30:0] period;
        logic [30:0] duty;
    } pwm_req_t;

    typedef struct {
        logic [31:0] clk_hz;
        int          count;
    } phase_t;

    localparam int LIMIT_CYCLES = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [63:0] s_tdata = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [31:0] m_tdata;

    pwm_period_duty_register_calc DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    pwm_req_t    pending_reqs[$];
    logic [31:0] expected_regs[$];
    logic [31:0] clk_rate_hz;
    int          mismatches = 0;
    int          cycle_count = 0;
    bit          stall_long = 1'b0;
    bit          drain_pause = 1'b0;
    int          send_gap = 0;
    int          recv_gap = 0;

    // Compute the packed register word for one request
    function automatic logic [31:0] calc_regs(logic [31:0] hz, pwm_req_t r);
        logic [63:0] cycles;
        logic [63:0] pre;
        logic [63:0] pv;
        logic [63:0] dc;
        logic [1:0]  st;
        logic        full;
        cycles = (64'(hz) * 64'(r.period)) / 64'(NS_PER_SECOND);
        if (cycles < 64'd1) cycles = 64'd1;
        pre = (cycles - 64'd1) / 64'(PERIOD_STEPS);
        pv = cycles / (pre + 64'd1) - 64'd1;
        dc = 64'd0;
        st = ST_OK;
        full = 1'b0;
        if (pre > 64'(MAX_PRESCALE)) begin
            st = ST_PRESCALE;
            pre = 64'd0;
            pv = 64'd0;
        end else if (r.duty == r.period) begin
            full = 1'b1;
        end else if (r.period == 31'd0) begin
            st = ST_ZERO;
            pre = 64'd0;
            pv = 64'd0;
        end else if (r.duty > r.period) begin
            dc = 64'(DUTY_SAT);
        end else begin
            dc = ((pv + 64'd1) * 64'(r.duty)) / 64'(r.period);
            if (dc > 64'(DUTY_SAT)) dc = 64'(DUTY_SAT);
        end
        return {1'b0, full, dc[10:0], pv[9:0], pre[5:0], st, r.channel};
    endfunction

    function automatic logic [30:0] rand_time();
        case ($urandom_range(0, 5))
            0: return 31'($urandom_range(0, 20));
            1: return 31'($urandom_range(0, 100000));
            2: return 31'($urandom_range(0, 10000000));
            3: return 31'h7fffffff - 31'($urandom_range(0, 3));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 3) != 0) return 0;
        if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Drive requests from the queue, keeping valid high across back-to-back items
    always @(posedge aclk) begin
        int       gap;
        pwm_req_t nx;
        if (aresetn) begin
            gap = send_gap;
            if (s_tvalid && s_tready) begin
                expected_regs.push_back(calc_regs(clk_rate_hz, pending_reqs.pop_front()));
                gap = gap_len();
            end else if (!s_tvalid && gap > 0) begin
                gap = gap - 1;
            end
            if (s_tvalid && !s_tready) begin
                // hold the offered request
                s_tvalid <= 1'b1;
            end else if (gap == 0 && !drain_pause && pending_reqs.size() > 0) begin
                nx = pending_reqs[0];
                s_tdata  <= {1'b0, nx.duty, nx.period, nx.channel};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
            send_gap <= gap;
        end
    end

    // Randomly hold off the result side; one long hold on request
    always @(posedge aclk) begin
        if (stall_long) begin
            recv_gap <= 300;
            m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_tready <= 1'b0;
        end else begin
            recv_gap <= gap_len();
            m_tready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_regs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                logic [31:0] exp_w;
                exp_w = expected_regs.pop_front();
                if (exp_w !== m_tdata) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", exp_w, m_tdata);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || s_tvalid || expected_regs.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_clock(logic [31:0] hz);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= hz;
        clk_rate_hz <= hz;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic add_req(logic ch, logic [30:0] p, logic [30:0] d);
        pwm_req_t r;
        r.channel = ch;
        r.period = p;
        r.duty = d;
        pending_reqs.push_back(r);
    endtask

    initial begin
        phase_t phases[6];
        logic [30:0] p;
        clk_rate_hz = CLOCK_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes and special cases at the reset clock rate
        add_req(1'b0, 31'd0, 31'd0);
        add_req(1'b1, 31'd0, 31'd5);
        add_req(1'b0, 31'h7fffffff, 31'h7fffffff);
        add_req(1'b1, 31'h7fffffff, 31'd0);
        add_req(1'b0, 31'd1000, 31'd500);
        add_req(1'b1, 31'd1000, 31'd2000);
        add_req(1'b0, 31'd78769, 31'd40000);
        add_req(1'b1, 31'd5000000, 31'd1);
        add_req(1'b0, 31'd5041230, 31'd5041229);
        add_req(1'b1, 31'd1, 31'h7fffffff);
        wait_idle();

        // Zero clock rate and maximum clock rate
        write_clock(32'd0);
        add_req(1'b0, 31'h7fffffff, 31'd3);
        add_req(1'b1, 31'd10, 31'd10);
        wait_idle();
        write_clock(32'hffffffff);
        add_req(1'b0, 31'h7fffffff, 31'd100);
        add_req(1'b1, 31'd15, 31'd7);
        add_req(1'b0, 31'd16000, 31'd8000);
        wait_idle();

        phases[0] = '{32'd13000000, 400};
        phases[1] = '{32'd1, 200};
        phases[2] = '{32'hffffffff, 300};
        phases[3] = '{32'd100000000, 400};
        phases[4] = '{32'd0, 100};
        phases[5] = '{32'h5a5a5a5a, 400};
        foreach (phases[i]) begin
            write_clock(phases[i].clk_hz);
            if (i == 3) stall_long <= 1'b1;
            for (int n = 0; n < phases[i].count; n++) begin
                p = rand_time();
                case ($urandom_range(0, 4))
                    0: add_req(1'($urandom), p, p);
                    1: add_req(1'($urandom), p, p + 31'($urandom_range(1, 9)));
                    2: add_req(1'($urandom), p, rand_time());
                    default: add_req(1'($urandom), p,
                                     31'(64'(p) * $urandom_range(0, 1000) / 1000));
                endcase
            end
            @(posedge aclk);
            stall_long <= 1'b0;
            if (i == 1) begin
                drain_pause <= 1'b1;
                repeat (3) @(posedge aclk);
                while (expected_regs.size() > 0 || s_tvalid) @(posedge aclk);
                drain_pause <= 1'b0;
            end
            wait_idle();
        end

        if (mismatches == 0 && expected_regs.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
